// File: design/wrh_pkg.sv
`default_nettype none

package wrh_pkg;

    localparam int MAX_BINS_DEF = 2048;

    localparam int SAMPLE_W   = 8;
    localparam int BIN_W      = 11;
    localparam int WIDTH_W    = 11;
    localparam int PEAK_W     = 8;
    localparam int SUM_W      = 32;
    localparam int LEN_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int PEAK_OFFSET = 125;

    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = -8'sd110;
    localparam logic [LEN_W-1:0]           LENGTH_RST    = 12'd1200;
    localparam logic [BIN_W-1:0]           SUS_LOW_RST   = 11'd933;
    localparam logic [BIN_W-1:0]           SUS_HIGH_RST  = 11'd983;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_LENGTH    = 3'd1,
        CFG_SUS_LOW   = 3'd2,
        CFG_SUS_HIGH  = 3'd3,
        CFG_REPORT    = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    typedef enum logic {
        KIND_RECORD = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

    typedef struct packed {
        logic [SUM_W-1:0] count;
        logic [SUM_W-1:0] width;
        logic [SUM_W-1:0] inten;
    } sums_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] threshold;
        logic [LEN_W-1:0]           waveform_length;
        logic [BIN_W-1:0]           suspect_low;
        logic [BIN_W-1:0]           suspect_high;
        logic                       report_suspect;
    } cfg_t;

    // one result-producing transaction headed for the bin update stage
    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic              in_range;
        logic [BIN_W-1:0]  bin;
        logic [LEN_W-1:0]  width;
        logic [PEAK_W-1:0] inten;
        logic              suspect;
    } req_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/wrh_if.sv
`default_nettype none

interface wrh_in_if import wrh_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [BIN_W-1:0]           bin_index;

    modport source (output valid, output cmd, output sample, output bin_index, input ready);
    modport sink   (input valid, input cmd, input sample, input bin_index, output ready);
endinterface

interface wrh_out_if import wrh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [BIN_W-1:0]    bin;
    logic [WIDTH_W-1:0]  return_width;
    logic [PEAK_W-1:0]   return_peak;
    logic                suspect;
    logic [SUM_W-1:0]    hit_count;
    logic [SUM_W-1:0]    width_total;
    logic [SUM_W-1:0]    intensity_total;
    logic [SUM_W-1:0]    all_returns;

    modport source (
        output valid, output kind, output bin, output return_width, output return_peak,
        output suspect, output hit_count, output width_total, output intensity_total,
        output all_returns, input ready
    );
    modport sink (
        input valid, input kind, input bin, input return_width, input return_peak,
        input suspect, input hit_count, input width_total, input intensity_total,
        input all_returns, output ready
    );
endinterface

`default_nettype wire

// File: design/waveform_return_range_histogram.sv
// path: an accepted transaction goes through the ram read stage, then the result register
// throughput: one transaction per cycle unless the result stalls, set by the single read
// and write port of the bin ram
// a sample and its later return record never collide: write data is forwarded into the update
// reset: control registers clear and configuration registers load defaults at once, then a
// sweep zeroes every bin ram entry, during which no transaction is accepted
`default_nettype none

module waveform_return_range_histogram import wrh_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    wrh_in_if.sink                     waveform,
    wrh_out_if.source                  result
);

    localparam int AW = $clog2(MAX_BINS);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    req_t          req;
    logic [AW-1:0] addr;
    logic          fire;
    logic          busy;
    logic          can_take;
    sums_t         rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    sums_t         wr_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD: cfg_next.threshold       = $signed(cfg_data[SAMPLE_W-1:0]);
                CFG_LENGTH:    cfg_next.waveform_length = cfg_data[LEN_W-1:0];
                CFG_SUS_LOW:   cfg_next.suspect_low     = cfg_data[BIN_W-1:0];
                CFG_SUS_HIGH:  cfg_next.suspect_high    = cfg_data[BIN_W-1:0];
                CFG_REPORT:    cfg_next.report_suspect  = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold       <= THRESHOLD_RST;
            cfg_reg.waveform_length <= LENGTH_RST;
            cfg_reg.suspect_low     <= SUS_LOW_RST;
            cfg_reg.suspect_high    <= SUS_HIGH_RST;
            cfg_reg.report_suspect  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign waveform.ready = !busy && can_take;
    assign fire           = waveform.valid && waveform.ready;

    wrh_detect #(
        .MAX_BINS (MAX_BINS)
    ) u_detect (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .cmd       (waveform.cmd),
        .sample    (waveform.sample),
        .bin_index (waveform.bin_index),
        .cfg       (cfg_reg),
        .req       (req),
        .addr      (addr)
    );

    wrh_ram #(
        .MAX_BINS (MAX_BINS)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (fire),
        .rd_addr (addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .busy    (busy)
    );

    wrh_update #(
        .MAX_BINS (MAX_BINS)
    ) u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .req      (req),
        .addr     (addr),
        .rd_data  (rd_data),
        .can_take (can_take),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .result   (result)
    );

endmodule

`default_nettype wire

// File: design/wrh_ram.sv
`default_nettype none

module wrh_ram import wrh_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF,
    localparam int AW = $clog2(MAX_BINS)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output sums_t              rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  sums_t              wr_data,
    output logic               busy
);

    sums_t           mem [MAX_BINS];
    sums_t           rd_data_reg;
    logic            clr_busy_reg;
    logic            clr_busy_next;
    logic [AW-1:0]   clr_addr_reg;
    logic [AW-1:0]   clr_addr_next;
    logic            we;
    logic [AW-1:0]   waddr;
    sums_t           wdata;

    // clearing sweep after reset, one entry per cycle
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(MAX_BINS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        we    = clr_busy_reg | wr_en;
        waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
        wdata = clr_busy_reg ? sums_t'('0) : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

// File: design/wrh_detect.sv
`default_nettype none

module wrh_detect import wrh_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF,
    localparam int AW = $clog2(MAX_BINS)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       fire,
    input  wire logic                       cmd,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic [BIN_W-1:0]           bin_index,
    input  cfg_t                            cfg,
    output req_t                            req,
    output logic [AW-1:0]                   addr
);

    logic [AW-1:0]              position_reg;
    logic [AW-1:0]              position_next;
    logic                       in_return_reg;
    logic                       in_return_next;
    logic [AW-1:0]              start_reg;
    logic [AW-1:0]              start_next;
    logic signed [SAMPLE_W-1:0] peak_reg;
    logic signed [SAMPLE_W-1:0] peak_next;
    logic [AW-1:0]              peak_pos_reg;
    logic [AW-1:0]              peak_pos_next;

    logic [31:0]                len_eff;
    logic [AW-1:0]              last_pos;
    logic                       is_read;
    logic                       above;
    logic                       closing;
    logic [AW-1:0]              span;
    logic signed [PEAK_W:0]     pk;

    always_comb
    begin
        if (cfg.waveform_length == '0)
        begin
            len_eff = 32'd1;
        end
        else if (32'(cfg.waveform_length) > 32'(MAX_BINS))
        begin
            len_eff = 32'(MAX_BINS);
        end
        else
        begin
            len_eff = 32'(cfg.waveform_length);
        end
        last_pos = AW'(len_eff - 32'd1);
    end

    always_comb
    begin
        is_read = (cmd == CMD_READ);
        above   = $signed(sample) > $signed(cfg.threshold);
        closing = !is_read && in_return_reg && !above;
        span    = position_reg - start_reg;
        pk      = $signed({peak_reg[SAMPLE_W-1], peak_reg}) + (PEAK_W+1)'(PEAK_OFFSET);
    end

    always_comb
    begin
        position_next  = position_reg;
        in_return_next = in_return_reg;
        start_next     = start_reg;
        peak_next      = peak_reg;
        peak_pos_next  = peak_pos_reg;
        if (fire && !is_read)
        begin
            if (!in_return_reg)
            begin
                if (above)
                begin
                    in_return_next = 1'b1;
                    start_next     = position_reg;
                    peak_next      = sample;
                    peak_pos_next  = position_reg;
                end
            end
            else
            begin
                if (sample > peak_reg)
                begin
                    peak_next     = sample;
                    peak_pos_next = position_reg;
                end
                if (!above)
                begin
                    in_return_next = 1'b0;
                end
            end
            if (position_reg >= last_pos)
            begin
                position_next  = '0;
                in_return_next = 1'b0;
            end
            else
            begin
                position_next = position_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            in_return_reg <= 1'b0;
            start_reg     <= '0;
            peak_reg      <= '0;
            peak_pos_reg  <= '0;
        end
        else
        begin
            position_reg  <= position_next;
            in_return_reg <= in_return_next;
            start_reg     <= start_next;
            peak_reg      <= peak_next;
            peak_pos_reg  <= peak_pos_next;
        end
    end

    always_comb
    begin
        req = '0;
        req.valid = is_read || closing;
        if (is_read)
        begin
            req.kind     = KIND_READ;
            req.in_range = 32'(bin_index) < 32'(MAX_BINS);
            req.bin      = bin_index;
            addr         = AW'(bin_index);
        end
        else
        begin
            req.kind     = KIND_RECORD;
            req.in_range = 1'b1;
            req.bin      = BIN_W'(peak_pos_reg);
            req.width    = LEN_W'(span);
            req.inten    = pk[PEAK_W] ? '0 : pk[PEAK_W-1:0];
            req.suspect  = cfg.report_suspect
                           && (32'(peak_pos_reg) >= 32'(cfg.suspect_low))
                           && (32'(peak_pos_reg) <= 32'(cfg.suspect_high));
            addr         = peak_pos_reg;
        end
    end

endmodule

`default_nettype wire

// File: design/wrh_update.sv
`default_nettype none

module wrh_update import wrh_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF,
    localparam int AW = $clog2(MAX_BINS)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  req_t               req,
    input  wire logic [AW-1:0] addr,
    input  sums_t              rd_data,
    output logic               can_take,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output sums_t              wr_data,
    wrh_out_if.source          result
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    req_t               s1_req_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               fwd_reg;
    sums_t              fwd_data_reg;
    logic [SUM_W-1:0]   total_reg;
    logic [SUM_W-1:0]   total_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_kind_reg;
    logic [BIN_W-1:0]   out_bin_reg;
    logic [WIDTH_W-1:0] out_width_reg;
    logic [PEAK_W-1:0]  out_peak_reg;
    logic               out_suspect_reg;
    sums_t              out_sums_reg;
    logic [SUM_W-1:0]   out_all_reg;

    logic               adv;
    logic               s1_fire;
    logic               is_rec;
    sums_t              base;
    sums_t              updated;
    sums_t              shown;
    logic [SUM_W-1:0]   total_inc;

    always_comb
    begin
        adv       = !out_valid_reg || result.ready;
        s1_fire   = s1_valid_reg && adv;
        can_take  = !s1_valid_reg || adv;
        is_rec    = (s1_req_reg.kind == KIND_RECORD);
        // a write at the edge of this transaction's read is not in the read data
        base      = fwd_reg ? fwd_data_reg : rd_data;
        updated.count = sat_add(base.count, SUM_W'(1));
        updated.width = sat_add(base.width, SUM_W'(s1_req_reg.width));
        updated.inten = sat_add(base.inten, SUM_W'(s1_req_reg.inten));
        total_inc = sat_add(total_reg, SUM_W'(1));
        wr_en     = s1_fire && is_rec;
        wr_addr   = s1_addr_reg;
        wr_data   = updated;
        if (is_rec)
        begin
            shown = updated;
        end
        else if (s1_req_reg.in_range)
        begin
            shown = base;
        end
        else
        begin
            shown = '0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (fire)
        begin
            s1_valid_next = req.valid;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = adv ? s1_valid_reg : out_valid_reg;
        total_next     = wr_en ? total_inc : total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            if (fire)
            begin
                fwd_reg <= wr_en && (wr_addr == addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_req_reg   <= req;
            s1_addr_reg  <= addr;
            fwd_data_reg <= wr_data;
        end
        if (s1_fire)
        begin
            out_kind_reg    <= s1_req_reg.kind;
            out_bin_reg     <= s1_req_reg.bin;
            out_width_reg   <= WIDTH_W'(s1_req_reg.width);
            out_peak_reg    <= s1_req_reg.inten;
            out_suspect_reg <= s1_req_reg.suspect;
            out_sums_reg    <= shown;
            out_all_reg     <= is_rec ? total_inc : total_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.kind            = out_kind_reg;
    assign result.bin             = out_bin_reg;
    assign result.return_width    = out_width_reg;
    assign result.return_peak     = out_peak_reg;
    assign result.suspect         = out_suspect_reg;
    assign result.hit_count       = out_sums_reg.count;
    assign result.width_total     = out_sums_reg.width;
    assign result.intensity_total = out_sums_reg.inten;
    assign result.all_returns     = out_all_reg;

endmodule

`default_nettype wire

// File: design/wrh_checker.sv
`default_nettype none

module wrh_checker import wrh_pkg::*; (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               kind,
    input wire logic [BIN_W-1:0]   bin,
    input wire logic [WIDTH_W-1:0] return_width,
    input wire logic [PEAK_W-1:0]  return_peak,
    input wire logic               suspect,
    input wire logic [SUM_W-1:0]   hit_count,
    input wire logic [SUM_W-1:0]   all_returns
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin) && $stable(hit_count)
                                    && $stable(all_returns))
        else $error("stalled result changed");

    a_readout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_READ |-> return_width == '0 && return_peak == '0 && !suspect)
        else $error("readout carries return fields");

    // a record includes its own update
    a_record_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_RECORD |-> hit_count != '0 && all_returns != '0
                                             && return_peak <= 8'd252)
        else $error("record sums miss their own return");

    // ram sweep blocks input right after reset
    a_sweep_block: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("input accepted during clearing sweep");

endmodule

bind waveform_return_range_histogram wrh_checker u_wrh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (waveform.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .kind         (result.kind),
    .bin          (result.bin),
    .return_width (result.return_width),
    .return_peak  (result.return_peak),
    .suspect      (result.suspect),
    .hit_count    (result.hit_count),
    .all_returns  (result.all_returns)
);

`default_nettype wire
